>>> hdl/atkd_pkg.sv
package atkd_pkg;

  localparam int NUM_ROUNDS     = 10;
  localparam int UID_BYTES_DEF  = 4;
  localparam int KEY_BYTES_DEF  = 6;
  localparam int CFG_IDX_W      = 2;
  localparam int DKEY_W         = 48;

  localparam logic [1:0] CMD_DERIVE  = 2'd0;
  localparam logic [1:0] CMD_ENCRYPT = 2'd1;
  localparam logic [1:0] CMD_DECRYPT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_UID_KEY_HI  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UID_KEY_LO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_KEY_HI = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_KEY_LO = 2'd3;

  localparam logic [7:0] RCON [NUM_ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] GF_POLY = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Key expansion beat: original key, latest round key, block and command.
  typedef struct packed {
    logic [1:0]   cmd;
    logic [127:0] key0;
    logic [127:0] rk;
    logic [127:0] blk;
  } kx_beat_t;

  // Round beat: cipher state and the round key for the next stage.
  typedef struct packed {
    logic [1:0]   cmd;
    logic [127:0] st;
    logic [127:0] rk;
  } rd_beat_t;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
    sub_rot = {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[127:96] ^ sub_rot(k[31:0], rc);
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    key_fwd = {n0, n1, n2, n3};
  endfunction

  function automatic logic [127:0] key_bwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    p0 = k[127:96] ^ sub_rot(p3, rc);
    key_bwd = {p0, p1, p2, p3};
  endfunction

  function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] res;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      res[127-8*i -: 8] = t[i];
    end
    fwd_round = res ^ k;
  endfunction

  function automatic logic [127:0] inv_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic mix);
    logic [7:0] t [16];
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [127:0] res;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*((c+r)%4)+r] = INV_SBOX[s[127-8*(4*c+r) -: 8]] ^ k[127-8*(4*((c+r)%4)+r) -: 8];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        for (int j = 0; j < 4; j++) begin
          a[j]  = t[4*c+j];
          m2[j] = xtime(a[j]);
          m4[j] = xtime(m2[j]);
          m8[j] = xtime(m4[j]);
          m9[j] = m8[j] ^ a[j];
          mb[j] = m8[j] ^ m2[j] ^ a[j];
          md[j] = m8[j] ^ m4[j] ^ a[j];
          me[j] = m8[j] ^ m4[j] ^ m2[j];
        end
        t[4*c]   = me[0] ^ mb[1] ^ md[2] ^ m9[3];
        t[4*c+1] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
        t[4*c+2] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
        t[4*c+3] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
      end
    end
    for (int i = 0; i < 16; i++) begin
      res[127-8*i -: 8] = t[i];
    end
    inv_round = res;
  endfunction

endpackage

>>> hdl/atkd_in_if.sv
interface atkd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] tag_id;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  modport source (output valid, cmd, tag_id, block_hi, block_lo, input ready);
  modport sink   (input valid, cmd, tag_id, block_hi, block_lo, output ready);
endinterface

>>> hdl/atkd_out_if.sv
interface atkd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_hi;
  logic [63:0] data_lo;
  logic [47:0] derived_key;
  modport source (output valid, data_hi, data_lo, derived_key, input ready);
  modport sink   (input valid, data_hi, data_lo, derived_key, output ready);
endinterface

>>> hdl/atkd_cfg_if.sv
interface atkd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/aes128_tag_key_derive_and_cipher_top.sv
// AES-128 ECB engine for tag work: one block per beat on req, one result beat on rsp.
// Command derive repeats the leading identifier bytes of tag_id over a 16-byte block,
// encrypts it under the identifier key and also returns its leading bytes as
// derived_key; encrypt and decrypt work on block_hi:block_lo under the data key; the
// unused command code returns an all-zero result. The pipeline is fully unrolled and
// accepts one block every clock while rsp is ready. From an accepted request beat to a
// valid response beat: ten stages run the forward key schedule to reach the last round
// key, one stage adds the first round key, ten round stages each do one cipher round
// while stepping the round key (forward for encrypt, backward for decrypt), and one
// output register holds the result. Each stage stalls only when it holds a beat that
// its successor cannot take, so bubbles close up. Keys reset to zero and are written
// on cfg, which never stalls; write them only while no block is in flight.
module aes128_tag_key_derive_and_cipher_top #(
  parameter int UID_BYTES = atkd_pkg::UID_BYTES_DEF,
  parameter int KEY_BYTES = atkd_pkg::KEY_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  atkd_in_if.sink    req,
  atkd_out_if.source rsp,
  atkd_cfg_if.sink   cfg
);
  import atkd_pkg::*;

  localparam int DK_W = 8 * KEY_BYTES;

  // Key registers, written through the configuration channel.
  logic [63:0] uid_key_hi, uid_key_lo, data_key_hi, data_key_lo;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      uid_key_hi  <= '0;
      uid_key_lo  <= '0;
      data_key_hi <= '0;
      data_key_lo <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_UID_KEY_HI:  uid_key_hi  <= cfg.data;
        REG_UID_KEY_LO:  uid_key_lo  <= cfg.data;
        REG_DATA_KEY_HI: data_key_hi <= cfg.data;
        REG_DATA_KEY_LO: data_key_lo <= cfg.data;
        default: ;
      endcase
    end
  end

  // Entry: build the plaintext for a derive beat and pick the key for the command.
  kx_beat_t entry_beat;
  logic [127:0] uid_block;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      uid_block[127-8*i -: 8] = req.tag_id[31-8*(i % UID_BYTES) -: 8];
    end
    entry_beat.cmd = req.cmd;
    if (req.cmd == CMD_DERIVE) begin
      entry_beat.blk  = uid_block;
      entry_beat.key0 = {uid_key_hi, uid_key_lo};
    end else begin
      entry_beat.blk  = {req.block_hi, req.block_lo};
      entry_beat.key0 = {data_key_hi, data_key_lo};
    end
    entry_beat.rk = entry_beat.key0;
  end

  // Key schedule stages: stage j leaves round key j+1 in the beat.
  logic     kx_vld [NUM_ROUNDS];
  logic     kx_rdy [NUM_ROUNDS];
  kx_beat_t kx_beat [NUM_ROUNDS];
  logic     init_rdy;

  assign req.ready = kx_rdy[0];

  for (genvar j = 0; j < NUM_ROUNDS; j++) begin : g_key
    atkd_key_stage #(.RC_IDX(j)) u_key (
      .clk       (clk),
      .rst       (rst),
      .in_valid  ((j == 0) ? req.valid : kx_vld[(j == 0) ? 0 : j-1]),
      .in_beat   ((j == 0) ? entry_beat : kx_beat[(j == 0) ? 0 : j-1]),
      .in_ready  (kx_rdy[j]),
      .out_valid (kx_vld[j]),
      .out_beat  (kx_beat[j]),
      .out_ready ((j == NUM_ROUNDS-1) ? init_rdy : kx_rdy[(j == NUM_ROUNDS-1) ? 0 : j+1])
    );
  end

  // Initial key addition. Encrypt starts from the original key and hands round key 1
  // on; decrypt starts from the last round key and hands round key 9 on.
  logic     rd_vld [NUM_ROUNDS];
  logic     rd_rdy [NUM_ROUNDS];
  rd_beat_t rd_beat [NUM_ROUNDS];
  logic     init_vld;
  rd_beat_t init_beat, init_beat_next;
  kx_beat_t kx_last;

  assign kx_last = kx_beat[NUM_ROUNDS-1];

  always_comb begin
    init_beat_next.cmd = kx_last.cmd;
    if (kx_last.cmd == CMD_DECRYPT) begin
      init_beat_next.st = kx_last.blk ^ kx_last.rk;
      init_beat_next.rk = key_bwd(kx_last.rk, RCON[NUM_ROUNDS-1]);
    end else begin
      init_beat_next.st = kx_last.blk ^ kx_last.key0;
      init_beat_next.rk = key_fwd(kx_last.key0, RCON[0]);
    end
  end

  assign init_rdy = !init_vld || rd_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      init_vld <= 1'b0;
    end else if (init_rdy) begin
      init_vld <= kx_vld[NUM_ROUNDS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (init_rdy && kx_vld[NUM_ROUNDS-1]) begin
      init_beat <= init_beat_next;
    end
  end

  // Cipher rounds.
  logic out_rdy;

  for (genvar j = 0; j < NUM_ROUNDS; j++) begin : g_round
    atkd_round_stage #(.ROUND(j+1)) u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  ((j == 0) ? init_vld : rd_vld[(j == 0) ? 0 : j-1]),
      .in_beat   ((j == 0) ? init_beat : rd_beat[(j == 0) ? 0 : j-1]),
      .in_ready  (rd_rdy[j]),
      .out_valid (rd_vld[j]),
      .out_beat  (rd_beat[j]),
      .out_ready ((j == NUM_ROUNDS-1) ? out_rdy : rd_rdy[(j == NUM_ROUNDS-1) ? 0 : j+1])
    );
  end

  // Output register. The unused command code clears the whole result, and only a
  // derive beat carries a derived key.
  rd_beat_t    rd_last;
  logic        out_vld;
  logic [1:0]  out_cmd;
  logic [63:0] out_hi, out_lo;
  logic [47:0] out_dk;
  logic [47:0] dk_next;
  logic [127:0] st_next;

  assign rd_last = rd_beat[NUM_ROUNDS-1];

  always_comb begin
    st_next = '0;
    dk_next = '0;
    if (rd_last.cmd == CMD_DERIVE) begin
      st_next = rd_last.st;
      dk_next = DKEY_W'(rd_last.st[127 -: DK_W]);
    end else if (rd_last.cmd == CMD_ENCRYPT || rd_last.cmd == CMD_DECRYPT) begin
      st_next = rd_last.st;
    end
  end

  assign out_rdy = !out_vld || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_rdy) begin
      out_vld <= rd_vld[NUM_ROUNDS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && rd_vld[NUM_ROUNDS-1]) begin
      out_cmd <= rd_last.cmd;
      out_hi  <= st_next[127:64];
      out_lo  <= st_next[63:0];
      out_dk  <= dk_next;
    end
  end

  assign rsp.valid       = out_vld;
  assign rsp.data_hi     = out_hi;
  assign rsp.data_lo     = out_lo;
  assign rsp.derived_key = out_dk;

  // An accepted request beat always lands in the first key stage.
  a_entry: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> kx_vld[0])
    else $error("accepted request beat lost at entry");

  // The initial-key stage holds its beat while the first round stalls.
  a_init_hold: assert property (@(posedge clk) disable iff (rst)
    init_vld && !rd_rdy[0] |=> init_vld && $stable(init_beat))
    else $error("initial stage dropped a stalled beat");

  // Only a derive beat may carry a derived key.
  a_dk_zero: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_cmd != CMD_DERIVE |-> out_dk == '0)
    else $error("derived key set for a non-derive command");

  // The unused command code yields an all-zero block.
  a_bad_cmd: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_cmd != CMD_DERIVE && out_cmd != CMD_ENCRYPT && out_cmd != CMD_DECRYPT
      |-> out_hi == '0 && out_lo == '0)
    else $error("unused command produced a nonzero block");
endmodule

>>> hdl/atkd_key_stage.sv
module atkd_key_stage #(
  parameter int RC_IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  atkd_pkg::kx_beat_t in_beat,
  output logic               in_ready,
  output logic               out_valid,
  output atkd_pkg::kx_beat_t out_beat,
  input  logic               out_ready
);
  import atkd_pkg::*;

  kx_beat_t beat_next;

  // One step of the forward key schedule per stage.
  always_comb begin
    beat_next    = in_beat;
    beat_next.rk = key_fwd(in_beat.rk, RCON[RC_IDX]);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_beat <= beat_next;
    end
  end
endmodule

>>> hdl/atkd_round_stage.sv
module atkd_round_stage #(
  parameter int ROUND = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  atkd_pkg::rd_beat_t in_beat,
  output logic               in_ready,
  output logic               out_valid,
  output atkd_pkg::rd_beat_t out_beat,
  input  logic               out_ready
);
  import atkd_pkg::*;

  localparam bit LAST   = (ROUND == NUM_ROUNDS);
  localparam int RC_ENC = LAST ? 0 : ROUND;
  localparam int RC_DEC = LAST ? 0 : NUM_ROUNDS - 1 - ROUND;

  rd_beat_t beat_next;

  // Encryption walks the key schedule forward, decryption walks it back.
  always_comb begin
    beat_next = in_beat;
    if (in_beat.cmd == CMD_DECRYPT) begin
      beat_next.st = inv_round(in_beat.st, in_beat.rk, !LAST);
      beat_next.rk = key_bwd(in_beat.rk, RCON[RC_DEC]);
    end else begin
      beat_next.st = fwd_round(in_beat.st, in_beat.rk, !LAST);
      beat_next.rk = key_fwd(in_beat.rk, RCON[RC_ENC]);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_beat <= beat_next;
    end
  end
endmodule
